FILE: design/sdcr_pkg.sv
// Shared types, constants and byte decode for the serial digit command responder.
`timescale 1ns / 1ps

package sdcr_pkg;

  // Number of digit cells in the display store (valid range 2 to 16).
  localparam int NUM_DIGITS = 8;
  // Digits reported on the result channel.
  localparam int SHOWN_DIGITS = (NUM_DIGITS < 8) ? NUM_DIGITS : 8;

  localparam int DIGIT_W = 4;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 8;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [CNT_W-1:0]   count_t;

  localparam digit_t BLANK_DIGIT = 4'd10;
  localparam count_t COUNT_MAX   = 8'hFF;

  localparam byte_t CH_CLEAR_C = 8'h43;
  localparam byte_t CH_CLEAR_N = 8'h4E;
  localparam byte_t CH_SKIP_A  = 8'h41;
  localparam byte_t CH_SKIP_T  = 8'h54;
  localparam byte_t CH_CR      = 8'h0D;
  localparam byte_t CH_LF      = 8'h0A;
  localparam byte_t CH_O       = 8'h4F;
  localparam byte_t CH_K       = 8'h4B;
  localparam byte_t NIBBLE_MASK = 8'h0F;

  // Event kinds carried on the input tuser bit.
  localparam logic EV_RX_BYTE = 1'b0;
  localparam logic EV_TX_RDY  = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_O    = 3'd1,
    PH_K    = 3'd2,
    PH_CR   = 3'd3,
    PH_LF   = 3'd4
  } tx_phase_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_IGNORE,
    CMD_LINE,
    CMD_DIGIT
  } rx_cmd_t;

  // Per-cycle control broadcast to every digit cell.
  typedef struct packed {
    logic clear;
    logic shift;
  } digit_ctl_t;

  // Request into the transmit sequencer.
  typedef struct packed {
    logic step;
    logic tx_ready;
    logic line_feed;
  } tx_req_t;

  // Sequencer state after the step and the character it sends.
  typedef struct packed {
    logic   sent;
    byte_t  ch;
    logic   irq_en;
    logic   rst_req;
    count_t pending;
  } tx_stat_t;

  function automatic rx_cmd_t decode_byte(byte_t b);
    rx_cmd_t cmd;
    if (b == CH_CLEAR_C || b == CH_CLEAR_N) begin
      cmd = CMD_CLEAR;
    end else if (b == CH_SKIP_A || b == CH_SKIP_T || b == CH_CR) begin
      cmd = CMD_IGNORE;
    end else if (b == CH_LF) begin
      cmd = CMD_LINE;
    end else begin
      cmd = CMD_DIGIT;
    end
    return cmd;
  endfunction

endpackage

FILE: design/serial_digit_command_responder_core.sv
// Top level of the serial digit command responder.
`timescale 1ns / 1ps

// The block takes one serial-port event per request on the input stream and
// returns exactly one result per event on the output stream. in_tuser gives
// the event kind (0 = byte received, 1 = transmitter ready) and in_tdata the
// received byte. A request is accepted every clock cycle for as long as the
// output side keeps up: the only thing that limits throughput is the output
// register, which holds a result until it is taken and lets the next request
// in on the same edge it is taken. Each result appears in the cycle after its
// request is accepted. The digit store is a chain of identical cells, one per
// digit, where each cell takes its lower neighbor's digit on a shift and cell
// 0 takes the low nibble of the received byte; a clear command blanks every
// cell to the value 10 all at once. Line feeds queue "OK", CR, LF responses
// (up to 255 pending) and transmitter-ready events walk the sender through
// those characters; the step after LF sends nothing and returns to idle.
// The result reports the state after the event; there is no start-up sweep.

module serial_digit_command_responder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [7:0] tx_byte, [8] tx_irq_enabled,
                                  // [9] reset_requested, [17:10] pending_count,
                                  // [49:18] display_digits, [55:50] zero
  output logic        out_tuser   // [0] tx_valid
);
  import sdcr_pkg::*;

  logic       accept;
  rx_cmd_t    cmd;
  digit_ctl_t dctl;
  tx_req_t    treq;
  tx_stat_t   tstat;

  digit_t cell_q   [NUM_DIGITS];
  digit_t cell_nxt [NUM_DIGITS];
  digit_t cell_in  [NUM_DIGITS];

  logic [31:0] shown;

  logic        out_valid_r;
  logic [55:0] out_data_r;
  logic        out_user_r;

  // The input is free whenever the output register is empty or drains now.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign cmd = decode_byte(in_tdata);

  assign dctl.clear = accept && (in_tuser == EV_RX_BYTE) && (cmd == CMD_CLEAR);
  assign dctl.shift = accept && (in_tuser == EV_RX_BYTE) && (cmd == CMD_DIGIT);

  assign treq.step      = accept;
  assign treq.tx_ready  = (in_tuser == EV_TX_RDY);
  assign treq.line_feed = (cmd == CMD_LINE);

  // Cell 0 takes the low nibble of the byte; every other cell its neighbor.
  assign cell_in[0] = digit_t'(in_tdata & NIBBLE_MASK);

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign cell_in[i] = cell_q[i-1];
    end
    sdcr_digit_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (dctl),
      .digit_in  (cell_in[i]),
      .digit_q   (cell_q[i]),
      .digit_nxt (cell_nxt[i])
    );
  end

  // Only the lowest eight digits are reported; missing positions read zero.
  for (genvar i = 0; i < 8; i++) begin : g_show
    if (i < SHOWN_DIGITS) begin : g_on
      assign shown[DIGIT_W*i +: DIGIT_W] = cell_nxt[i];
    end else begin : g_off
      assign shown[DIGIT_W*i +: DIGIT_W] = '0;
    end
  end

  sdcr_tx_seq u_tx (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (treq),
    .stat  (tstat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_user_r <= tstat.sent;
      out_data_r <= {6'd0, shown, tstat.pending, tstat.rst_req, tstat.irq_en, tstat.ch};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: design/sdcr_digit_cell.sv
// One digit cell of the display store chain.
`timescale 1ns / 1ps

module sdcr_digit_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  sdcr_pkg::digit_ctl_t ctl,
  input  sdcr_pkg::digit_t    digit_in,
  output sdcr_pkg::digit_t    digit_q,
  output sdcr_pkg::digit_t    digit_nxt
);
  import sdcr_pkg::*;

  digit_t digit_r;

  always_comb begin
    priority if (ctl.clear) begin
      digit_nxt = BLANK_DIGIT;
    end else if (ctl.shift) begin
      digit_nxt = digit_in;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= BLANK_DIGIT;
    end else begin
      digit_r <= digit_nxt;
    end
  end

  assign digit_q = digit_r;

endmodule

FILE: design/sdcr_tx_seq.sv
// Response sequencer: pending count, transmitter enable and the OK-CR-LF sender.
`timescale 1ns / 1ps

module sdcr_tx_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  sdcr_pkg::tx_req_t  req,
  output sdcr_pkg::tx_stat_t stat
);
  import sdcr_pkg::*;

  tx_phase_t phase_r, phase_nxt;
  count_t    pending_r, pending_nxt;
  logic      irq_en_r, irq_en_nxt;
  logic      rst_req_r, rst_req_nxt;
  logic      sent;
  byte_t     ch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      pending_r <= '0;
      irq_en_r  <= 1'b0;
      rst_req_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      pending_r <= pending_nxt;
      irq_en_r  <= irq_en_nxt;
      rst_req_r <= rst_req_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    pending_nxt = pending_r;
    irq_en_nxt  = irq_en_r;
    rst_req_nxt = rst_req_r;
    sent        = 1'b0;
    ch          = '0;
    if (req.step) begin
      if (!req.tx_ready) begin
        if (req.line_feed) begin
          if (pending_r != COUNT_MAX) begin
            pending_nxt = pending_r + 1'b1;
          end
          irq_en_nxt  = 1'b1;
          rst_req_nxt = 1'b1;
        end
      end else if (irq_en_r) begin
        unique case (phase_r)
          PH_O: begin
            phase_nxt = PH_K;
            sent      = 1'b1;
            ch        = CH_K;
          end
          PH_K: begin
            phase_nxt = PH_CR;
            sent      = 1'b1;
            ch        = CH_CR;
          end
          PH_CR: begin
            phase_nxt = PH_LF;
            sent      = 1'b1;
            ch        = CH_LF;
          end
          PH_LF: begin
            // Closing step of a response sends nothing.
            phase_nxt = PH_IDLE;
            if (pending_r == '0) begin
              irq_en_nxt = 1'b0;
            end
          end
          default: begin
            if (pending_r != '0) begin
              pending_nxt = pending_r - 1'b1;
            end
            phase_nxt = PH_O;
            sent      = 1'b1;
            ch        = CH_O;
          end
        endcase
      end
    end
  end

  assign stat = '{sent: sent, ch: ch, irq_en: irq_en_nxt, rst_req: rst_req_nxt,
                  pending: pending_nxt};

`ifndef ASSERT_OFF
  // A character only goes out while the transmitter is enabled.
  a_send_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    sent |-> irq_en_r)
    else $error("character sent with transmitter disabled");

  // The pending count never wraps from its maximum on a line feed.
  a_pending_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (req.step && !req.tx_ready && req.line_feed && pending_r == COUNT_MAX)
      |=> (pending_r == COUNT_MAX))
    else $error("pending count wrapped");

  // Once raised, the reset request stays raised.
  a_reset_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    rst_req_r |=> rst_req_r)
    else $error("reset request dropped");

  // The transmitter is never disabled while responses remain.
  a_no_disable_pending: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(irq_en_r) && !irq_en_r) |-> (pending_r == '0))
    else $error("transmitter disabled with responses pending");
`endif

endmodule
